@@ rtl/ewht_pkg.sv @@
// Package for the epoch window hash table.
// Holds the transaction structs, command codes, mix constants and controller/datapath types.
// No dependencies.
`default_nettype none

package ewht_pkg;

    localparam int BUCKET_COUNT_DEF = 256;
    localparam int POOL_ENTRIES_DEF = 1024;

    localparam logic [63:0] MIX_A = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_B = 64'h94D049BB133111EB;

    localparam logic [8:0] WINDOW_RESET = 9'd256;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_SWEEP  = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [63:0] key;
        logic [63:0] value;
    } t_in;

    typedef struct packed {
        logic        status;
        logic        found;
        logic [63:0] read_value;
        logic [9:0]  entry_index;
        logic [10:0] evicted;
    } t_out;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_MUL,
        OP_MIX,
        OP_MOD,
        OP_INS_RD,
        OP_INS_WR,
        OP_HEAD_RD,
        OP_LK_FIRST,
        OP_LK_NEXT,
        OP_SW_HEAD,
        OP_SW_FIRST,
        OP_SW_STEP
    } t_op;

    typedef enum logic [2:0] {
        RES_NONE,
        RES_ZERO,
        RES_FULL,
        RES_INS,
        RES_HIT,
        RES_SWEEP
    } t_res;

    typedef struct packed {
        t_op        op;
        logic [1:0] mstep;
        logic       mround;
        t_res       res;
    } t_ctl;

    typedef struct packed {
        logic free_ok;
        logic head_v;
        logic hit;
        logic next_v;
    } t_stat;

endpackage

`default_nettype wire

@@ rtl/ewht_datapath.sv @@
// Datapath of the epoch window hash table: hash unit, pool memories, free list, counters.
// Executes one command from the controller per cycle and reports status back.
// Depends on ewht_pkg.
`default_nettype none

module ewht_datapath #(
    parameter int BUCKET_COUNT = ewht_pkg::BUCKET_COUNT_DEF,
    parameter int POOL_ENTRIES = ewht_pkg::POOL_ENTRIES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire ewht_pkg::t_in  i_data,
    input  wire logic        i_cfg_we,
    input  wire logic [8:0]  i_cfg_data,
    input  wire ewht_pkg::t_ctl i_ctl,
    output ewht_pkg::t_stat  o_stat,
    output ewht_pkg::t_out   o_result
);

    localparam int BW = $clog2(BUCKET_COUNT);
    localparam int SW = $clog2(POOL_ENTRIES);
    localparam int CW = $clog2(POOL_ENTRIES + 1);

    logic [8:0]         r_window;
    logic [31:0]        r_epoch;
    logic [BW-1:0]      r_sweep;
    logic               r_free_v;
    logic [SW-1:0]      r_free_s;
    logic [CW-1:0]      r_bump;
    logic [BUCKET_COUNT-1:0] r_hvalid;

    logic [63:0]        r_key;
    logic [63:0]        r_value;
    logic [63:0]        r_x;
    logic [63:0]        r_acc;
    logic [BW-1:0]      r_rem;
    logic [31:0]        r_min_ep;
    logic [CW-1:0]      r_cnt;
    logic               r_cur_v;
    logic [SW-1:0]      r_cur_s;
    logic               r_hv;
    logic [SW-1:0]      r_head_q;
    logic [63:0]        r_key_q;
    logic [63:0]        r_val_q;
    logic [31:0]        r_ep_q;
    logic [SW:0]        r_next_q;
    ewht_pkg::t_out     r_result;

    logic [SW-1:0]      m_head [BUCKET_COUNT];
    logic [63:0]        m_key  [POOL_ENTRIES];
    logic [63:0]        m_val  [POOL_ENTRIES];
    logic [31:0]        m_ep   [POOL_ENTRIES];
    logic [SW:0]        m_next [POOL_ENTRIES];

    logic [63:0]        w_mconst;
    logic [31:0]        w_ma;
    logic [31:0]        w_mb;
    logic [63:0]        w_prod;
    logic [31:0]        w_win;
    logic [31:0]        w_min;
    logic [BW-1:0]      w_rem;
    logic [BW-1:0]      w_head_addr;
    logic [SW-1:0]      w_rd_addr;
    logic [SW-1:0]      w_ins_slot;
    logic [CW-1:0]      w_cnt_n;
    logic               w_head_rd;

    assign w_mconst = i_ctl.mround ? ewht_pkg::MIX_B : ewht_pkg::MIX_A;
    assign w_ma     = (i_ctl.mstep == 2'd2) ? r_x[63:32] : r_x[31:0];
    assign w_mb     = (i_ctl.mstep == 2'd1) ? w_mconst[63:32] : w_mconst[31:0];
    assign w_prod   = w_ma * w_mb;

    assign w_win = (32'(r_window) > 32'(BUCKET_COUNT)) ? 32'(BUCKET_COUNT) : 32'(r_window);
    assign w_min = (r_epoch >= w_win) ? (r_epoch - w_win) : 32'd0;

    always_comb begin
        logic [BW:0]   v_t;
        logic [BW-1:0] v_rem;
        v_rem = r_rem;
        for (int i = 0; i < 8; i++) begin
            v_t = {v_rem, r_x[63-i]};
            if (v_t >= (BW+1)'(BUCKET_COUNT)) begin
                v_t = v_t - (BW+1)'(BUCKET_COUNT);
            end
            v_rem = v_t[BW-1:0];
        end
        w_rem = v_rem;
    end

    assign w_head_addr = (i_ctl.op == ewht_pkg::OP_SW_HEAD) ? r_sweep : r_rem;
    assign w_head_rd   = (i_ctl.op == ewht_pkg::OP_INS_RD) || (i_ctl.op == ewht_pkg::OP_HEAD_RD)
                      || (i_ctl.op == ewht_pkg::OP_SW_HEAD);
    assign w_ins_slot  = r_free_v ? r_free_s : r_bump[SW-1:0];

    always_comb begin
        case (i_ctl.op)
            ewht_pkg::OP_INS_RD:   w_rd_addr = r_free_s;
            ewht_pkg::OP_LK_FIRST: w_rd_addr = r_head_q;
            ewht_pkg::OP_SW_FIRST: w_rd_addr = r_head_q;
            default:               w_rd_addr = r_next_q[SW-1:0];
        endcase
    end

    always_comb begin
        case (i_ctl.op)
            ewht_pkg::OP_SW_FIRST: w_cnt_n = '0;
            ewht_pkg::OP_SW_STEP:  w_cnt_n = r_cnt + CW'(1);
            default:               w_cnt_n = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= ewht_pkg::WINDOW_RESET;
            r_epoch  <= '0;
            r_sweep  <= '0;
            r_free_v <= 1'b0;
            r_free_s <= '0;
            r_bump   <= '0;
            r_hvalid <= '0;
        end else begin
            if (i_cfg_we) begin
                r_window <= i_cfg_data;
            end
            if (i_ctl.op == ewht_pkg::OP_SW_HEAD) begin
                r_hvalid[r_sweep] <= 1'b0;
            end
            if (i_ctl.op == ewht_pkg::OP_INS_WR) begin
                r_hvalid[r_rem] <= 1'b1;
                if (r_free_v) begin
                    r_free_v <= r_next_q[SW];
                    r_free_s <= r_next_q[SW-1:0];
                end else begin
                    r_bump <= r_bump + CW'(1);
                end
            end
            if (i_ctl.op == ewht_pkg::OP_SW_STEP) begin
                r_free_v <= r_cur_v;
                r_free_s <= r_cur_s;
            end
            if (i_ctl.res == ewht_pkg::RES_SWEEP) begin
                r_epoch <= r_epoch + 32'd1;
                r_sweep <= (r_sweep == BW'(BUCKET_COUNT - 1)) ? '0 : r_sweep + BW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= w_cnt_n;
        if (w_head_rd) begin
            r_head_q <= m_head[w_head_addr];
            r_hv     <= r_hvalid[w_head_addr];
        end
        case (i_ctl.op)
            ewht_pkg::OP_LOAD: begin
                r_key    <= i_data.key;
                r_value  <= i_data.value;
                r_x      <= i_data.key ^ (i_data.key >> 30);
                r_min_ep <= w_min;
            end
            ewht_pkg::OP_MUL: begin
                if (i_ctl.mstep == 2'd0) begin
                    r_acc <= w_prod;
                end else begin
                    r_acc <= {r_acc[63:32] + w_prod[31:0], r_acc[31:0]};
                end
            end
            ewht_pkg::OP_MIX: begin
                r_x   <= i_ctl.mround ? (r_acc ^ (r_acc >> 31)) : (r_acc ^ (r_acc >> 27));
                r_rem <= '0;
            end
            ewht_pkg::OP_MOD: begin
                r_rem <= w_rem;
                r_x   <= r_x << 8;
            end
            ewht_pkg::OP_SW_FIRST: begin
                r_cur_v <= r_hv;
                r_cur_s <= r_head_q;
            end
            ewht_pkg::OP_SW_STEP: begin
                r_cur_v <= r_next_q[SW];
                r_cur_s <= r_next_q[SW-1:0];
            end
            default: begin
            end
        endcase
        case (i_ctl.res)
            ewht_pkg::RES_ZERO: r_result <= '0;
            ewht_pkg::RES_FULL: begin
                r_result        <= '0;
                r_result.status <= 1'b1;
            end
            ewht_pkg::RES_INS: begin
                r_result             <= '0;
                r_result.entry_index <= 10'(w_ins_slot);
            end
            ewht_pkg::RES_HIT: begin
                r_result            <= '0;
                r_result.found      <= 1'b1;
                r_result.read_value <= r_val_q;
            end
            ewht_pkg::RES_SWEEP: begin
                r_result         <= '0;
                r_result.evicted <= 11'(w_cnt_n);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.op == ewht_pkg::OP_INS_WR) begin
            m_head[r_rem] <= w_ins_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.op == ewht_pkg::OP_INS_WR) begin
            m_key[w_ins_slot] <= r_key;
            m_val[w_ins_slot] <= r_value;
            m_ep[w_ins_slot]  <= r_epoch;
        end
        r_key_q <= m_key[w_rd_addr];
        r_val_q <= m_val[w_rd_addr];
        r_ep_q  <= m_ep[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.op == ewht_pkg::OP_INS_WR) begin
            m_next[w_ins_slot] <= {r_hv, r_head_q};
        end else if (i_ctl.op == ewht_pkg::OP_SW_STEP) begin
            m_next[r_cur_s] <= {r_free_v, r_free_s};
        end
        r_next_q <= m_next[w_rd_addr];
    end

    assign o_stat.free_ok = r_free_v || (r_bump < CW'(POOL_ENTRIES));
    assign o_stat.head_v  = r_hv;
    assign o_stat.hit     = (r_key_q == r_key) && (r_ep_q >= r_min_ep);
    assign o_stat.next_v  = r_next_q[SW];
    assign o_result       = r_result;

    a_ins_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.op == ewht_pkg::OP_INS_WR) |-> (r_free_v || (r_bump < CW'(POOL_ENTRIES))))
        else $error("insert without a free slot");

    a_sweep_cur: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.op == ewht_pkg::OP_SW_STEP) |-> r_cur_v)
        else $error("sweep step on null link");

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.res == ewht_pkg::RES_SWEEP) |-> (w_cnt_n <= CW'(POOL_ENTRIES)))
        else $error("sweep count beyond pool");

endmodule

`default_nettype wire

@@ rtl/ewht_ctrl.sv @@
// Controller of the epoch window hash table: sequences hash, insert, lookup walk and sweep.
// Drives datapath commands, reads datapath status. Depends on ewht_pkg.
`default_nettype none

module ewht_ctrl (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    input  wire logic [1:0]  i_command,
    input  wire ewht_pkg::t_stat i_stat,
    output ewht_pkg::t_ctl   o_ctl,
    output logic             busy,
    output logic             o_strobe
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_MIX,
        S_MOD,
        S_INS_RD,
        S_INS_WR,
        S_LK_HEAD,
        S_LK_FIRST,
        S_LK_CMP,
        S_SW_HEAD,
        S_SW_FIRST,
        S_SW_STEP
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_cnt, n_cnt;
    logic       r_round, n_round;
    logic [1:0] r_cmd, n_cmd;
    logic       r_done, n_done;

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_round      = r_round;
        n_cmd        = r_cmd;
        n_done       = 1'b0;
        o_ctl.op     = ewht_pkg::OP_NOP;
        o_ctl.mstep  = r_cnt[1:0];
        o_ctl.mround = r_round;
        o_ctl.res    = ewht_pkg::RES_NONE;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_ctl.op = ewht_pkg::OP_LOAD;
                    n_cmd    = i_command;
                    n_cnt    = '0;
                    n_round  = 1'b0;
                    if ((i_command == ewht_pkg::CMD_INSERT) ||
                        (i_command == ewht_pkg::CMD_LOOKUP)) begin
                        n_state = S_MUL;
                    end else if (i_command == ewht_pkg::CMD_SWEEP) begin
                        n_state = S_SW_HEAD;
                    end else begin
                        o_ctl.res = ewht_pkg::RES_ZERO;
                        n_done    = 1'b1;
                    end
                end
            end
            S_MUL: begin
                o_ctl.op = ewht_pkg::OP_MUL;
                if (r_cnt == 3'd2) begin
                    n_state = S_MIX;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            S_MIX: begin
                o_ctl.op = ewht_pkg::OP_MIX;
                n_cnt    = '0;
                if (!r_round) begin
                    n_round = 1'b1;
                    n_state = S_MUL;
                end else begin
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                o_ctl.op = ewht_pkg::OP_MOD;
                n_cnt    = r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    n_state = (r_cmd == ewht_pkg::CMD_INSERT) ? S_INS_RD : S_LK_HEAD;
                end
            end
            S_INS_RD: begin
                if (i_stat.free_ok) begin
                    o_ctl.op = ewht_pkg::OP_INS_RD;
                    n_state  = S_INS_WR;
                end else begin
                    o_ctl.res = ewht_pkg::RES_FULL;
                    n_done    = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_INS_WR: begin
                o_ctl.op  = ewht_pkg::OP_INS_WR;
                o_ctl.res = ewht_pkg::RES_INS;
                n_done    = 1'b1;
                n_state   = S_IDLE;
            end
            S_LK_HEAD: begin
                o_ctl.op = ewht_pkg::OP_HEAD_RD;
                n_state  = S_LK_FIRST;
            end
            S_LK_FIRST: begin
                if (i_stat.head_v) begin
                    o_ctl.op = ewht_pkg::OP_LK_FIRST;
                    n_state  = S_LK_CMP;
                end else begin
                    o_ctl.res = ewht_pkg::RES_ZERO;
                    n_done    = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_LK_CMP: begin
                if (i_stat.hit) begin
                    o_ctl.res = ewht_pkg::RES_HIT;
                    n_done    = 1'b1;
                    n_state   = S_IDLE;
                end else if (!i_stat.next_v) begin
                    o_ctl.res = ewht_pkg::RES_ZERO;
                    n_done    = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    o_ctl.op = ewht_pkg::OP_LK_NEXT;
                end
            end
            S_SW_HEAD: begin
                o_ctl.op = ewht_pkg::OP_SW_HEAD;
                n_state  = S_SW_FIRST;
            end
            S_SW_FIRST: begin
                o_ctl.op = ewht_pkg::OP_SW_FIRST;
                if (i_stat.head_v) begin
                    n_state = S_SW_STEP;
                end else begin
                    o_ctl.res = ewht_pkg::RES_SWEEP;
                    n_done    = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_SW_STEP: begin
                o_ctl.op = ewht_pkg::OP_SW_STEP;
                if (!i_stat.next_v) begin
                    o_ctl.res = ewht_pkg::RES_SWEEP;
                    n_done    = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_round <= 1'b0;
            r_cmd   <= ewht_pkg::CMD_INSERT;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_round <= n_round;
            r_cmd   <= n_cmd;
            r_done  <= n_done;
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_done;

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && ((i_command == ewht_pkg::CMD_INSERT) ||
         (i_command == ewht_pkg::CMD_LOOKUP) || (i_command == ewht_pkg::CMD_SWEEP))) |=> busy)
        else $error("accepted transaction did not start work");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == S_IDLE))
        else $error("result strobe while working");

endmodule

`default_nettype wire

@@ rtl/epoch_window_hash_table.sv @@
// Epoch window hash table top level. Insert reports a full table when no slot is free.
// Lookup visits the entries of a bucket chain; sweep frees the entries of one bucket.
// The hash (three 32x32 partial products per multiply, then an 8-bit-per-cycle bucket
// reduction) picks the bucket; chains in pool memory are walked one entry per cycle.
// One transaction at a time; results cannot be stalled; unused commands yield zero. Synchronous
// reset empties buckets and free list, clears epoch and cursors, sets window to 256.
`default_nettype none

module epoch_window_hash_table #(
    parameter int BUCKET_COUNT = ewht_pkg::BUCKET_COUNT_DEF,
    parameter int POOL_ENTRIES = ewht_pkg::POOL_ENTRIES_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire ewht_pkg::t_in  i_data,
    input  wire logic           i_cfg_we,
    input  wire logic [8:0]     i_cfg_data,
    output logic                o_strobe,
    output ewht_pkg::t_out      o_result
);

    ewht_pkg::t_ctl  w_ctl;
    ewht_pkg::t_stat w_stat;

    ewht_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_command (i_data.command),
        .i_stat    (w_stat),
        .o_ctl     (w_ctl),
        .busy      (busy),
        .o_strobe  (o_strobe)
    );

    ewht_datapath #(
        .BUCKET_COUNT (BUCKET_COUNT),
        .POOL_ENTRIES (POOL_ENTRIES)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_data     (i_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_ctl      (w_ctl),
        .o_stat     (w_stat),
        .o_result   (o_result)
    );

endmodule

`default_nettype wire
